// ----- hw/rtl/dlv_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal list validator package
// Shared constants, result codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dlv_pkg;

	// Table size and the widths that follow from it.
	localparam int MAX_ENTRIES     = 512;
	localparam int MAX_TOKEN_CHARS = 11;
	localparam int IDX_W           = $clog2(MAX_ENTRIES);
	localparam int CNT_W           = $clog2(MAX_ENTRIES + 1);
	localparam int MAG_W           = 37;
	localparam int VAL_W           = 32;
	localparam int NUM_W           = 10;
	localparam int STAT_W          = 3;

	localparam logic [NUM_W-1:0] CNT_SAT = '1;

	// Character codes.
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2d;

	// Range limits on the accumulated magnitude.
	localparam logic [MAG_W-1:0] POS_MAX = MAG_W'(64'h7fff_ffff);
	localparam logic [MAG_W-1:0] NEG_MAX = MAG_W'(64'h8000_0000);

	// Token status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_BAD_CHAR = 3'd1;
	localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd4;
	localparam logic [STAT_W-1:0] ST_NO_TOKEN = 3'd5;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd6;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_LAST,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept;   // an input beat is taken this cycle
		logic check;    // evaluate the closed token
		logic scan_rd;  // read the next stored value
		logic finish;   // load the result register and update list state
	} cmd_t;

	typedef struct packed {
		logic scan_needed;  // token is well formed and the table is not empty
		logic scan_last;    // the read issued now is the last stored entry
		logic out_free;     // the result register can take a new beat
	} sts_t;

	function automatic logic [NUM_W-1:0] sat10(input logic [31:0] x);
		logic [NUM_W-1:0] r;
		if (x > 32'(CNT_SAT)) begin
			r = CNT_SAT;
		end else begin
			r = x[NUM_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/dlv_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dlv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/dlv_ctrl.sv -----
// ----------------------------------------------------------------------------
// Decimal list validator controller
// Sequences byte intake, token check, duplicate scan and result hand-off.
// ----------------------------------------------------------------------------
module dlv_ctrl
	import dlv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_marks,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_marks) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = sts.scan_needed ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_last) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE);
		cmd.accept     = (state_q == S_IDLE) && in_valid;
		cmd.check      = (state_q == S_CHECK);
		cmd.scan_rd    = (state_q == S_SCAN);
		cmd.finish     = (state_q == S_FINISH) && sts.out_free;
	end

endmodule

// ----- hw/rtl/dlv_datapath.sv -----
// ----------------------------------------------------------------------------
// Decimal list validator datapath
// Token accumulator, checks, value table with duplicate compare, and the
// result register.
// ----------------------------------------------------------------------------
module dlv_datapath
	import dlv_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [7:0]               character,
	input  logic                     char_present,
	input  logic                     token_end,
	input  logic                     list_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [VAL_W-1:0]  value,
	output logic [NUM_W-1:0]         token_number,
	output logic [STAT_W-1:0]        token_status,
	output logic                     is_list_end,
	output logic                     list_valid,
	output logic [NUM_W-1:0]         accepted_count
);

	// Token state.
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic [3:0]       chars_q;
	logic             digits_q;
	logic             err_q;
	logic             tend_q;
	logic             lend_q;

	// List state.
	logic             failed_q;
	logic [CNT_W-1:0] count_q;
	logic [NUM_W-1:0] tok_q;

	// Check and scan state.
	logic              close_q;
	logic [STAT_W-1:0] pre_q;
	logic [VAL_W-1:0]  v_q;
	logic              dup_q;
	logic [IDX_W-1:0]  idx_q;
	logic              rd_valid_s1;
	logic [VAL_W-1:0]  rd_data;

	// Result register.
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] value_q;
	logic [NUM_W-1:0]        number_q;
	logic [STAT_W-1:0]       status_q;
	logic                    lend_out_q;
	logic                    list_valid_q;
	logic [NUM_W-1:0]        accepted_q;

	// Byte intake.
	logic             is_digit;
	logic [MAG_W-1:0] mag_next;

	assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
	assign mag_next = (mag_q << 3) + (mag_q << 1) + MAG_W'(character - CH_ZERO);

	// Token check.
	logic              close_c;
	logic [STAT_W-1:0] pre_c;
	logic [VAL_W-1:0]  v_c;

	always_comb begin
		close_c = tend_q || (chars_q != 4'd0);
		priority if (err_q || (neg_q && !digits_q)) begin
			pre_c = ST_BAD_CHAR;
		end else if (chars_q > 4'(MAX_TOKEN_CHARS)) begin
			pre_c = ST_TOO_LONG;
		end else if (neg_q ? (mag_q > NEG_MAX) : (mag_q > POS_MAX)) begin
			pre_c = ST_RANGE;
		end else begin
			pre_c = ST_OK;
		end
		v_c = neg_q ? (VAL_W'(0) - mag_q[VAL_W-1:0]) : mag_q[VAL_W-1:0];
	end

	// Result of a close.
	logic              full_c;
	logic [STAT_W-1:0] stat_c;
	logic              store_c;
	logic [NUM_W-1:0]  tok_n;
	logic [CNT_W-1:0]  cnt_n;
	logic              failed_n;

	always_comb begin
		full_c = (count_q >= CNT_W'(MAX_ENTRIES));
		if (close_q) begin
			priority if (pre_q != ST_OK) begin
				stat_c = pre_q;
			end else if (dup_q) begin
				stat_c = ST_DUP;
			end else if (full_c) begin
				stat_c = ST_FULL;
			end else begin
				stat_c = ST_OK;
			end
		end else begin
			stat_c = (lend_q && (tok_q == '0)) ? ST_NO_TOKEN : ST_OK;
		end
		store_c  = close_q && (stat_c == ST_OK);
		tok_n    = (close_q && (tok_q != CNT_SAT)) ? tok_q + 1'b1 : tok_q;
		cnt_n    = store_c ? count_q + 1'b1 : count_q;
		failed_n = failed_q || (stat_c != ST_OK);
	end

	assign sts.scan_needed = close_c && (pre_c == ST_OK) && (count_q != '0);
	assign sts.scan_last   = (idx_q == IDX_W'(count_q - 1'b1));
	assign sts.out_free    = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q    <= '0;
			neg_q    <= 1'b0;
			chars_q  <= '0;
			digits_q <= 1'b0;
			err_q    <= 1'b0;
			tend_q   <= 1'b0;
			lend_q   <= 1'b0;
		end else if (cmd.accept) begin
			tend_q <= token_end;
			lend_q <= list_end;
			if (char_present) begin
				if (is_digit) begin
					if (chars_q < 4'(MAX_TOKEN_CHARS)) begin
						mag_q <= mag_next;
					end
					digits_q <= 1'b1;
				end else if ((character == CH_MINUS) && (chars_q == 4'd0)) begin
					neg_q <= 1'b1;
				end else begin
					err_q <= 1'b1;
				end
				if (chars_q < 4'(MAX_TOKEN_CHARS + 1)) begin
					chars_q <= chars_q + 4'd1;
				end
			end
		end else if (cmd.finish) begin
			mag_q    <= '0;
			neg_q    <= 1'b0;
			chars_q  <= '0;
			digits_q <= 1'b0;
			err_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			count_q  <= '0;
			tok_q    <= '0;
		end else if (cmd.finish) begin
			if (lend_q) begin
				failed_q <= 1'b0;
				count_q  <= '0;
				tok_q    <= '0;
			end else begin
				failed_q <= failed_n;
				count_q  <= cnt_n;
				tok_q    <= tok_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q     <= 1'b0;
			dup_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			idx_q       <= '0;
		end else begin
			rd_valid_s1 <= cmd.scan_rd;
			if (cmd.check) begin
				close_q <= close_c;
				dup_q   <= 1'b0;
				idx_q   <= '0;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= idx_q + 1'b1;
				end
				if (rd_valid_s1 && (rd_data == v_q)) begin
					dup_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			pre_q <= pre_c;
			v_q   <= v_c;
		end
	end

	dlv_ram #(
		.WIDTH(VAL_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.finish && store_c),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(v_q),
		.rd_en  (cmd.scan_rd),
		.rd_addr(idx_q),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			value_q      <= store_c ? signed'(v_q) : '0;
			number_q     <= tok_n;
			status_q     <= stat_c;
			lend_out_q   <= lend_q;
			list_valid_q <= lend_q && !failed_n && (tok_n != '0);
			accepted_q   <= sat10(32'(cnt_n));
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign token_number   = number_q;
	assign token_status   = status_q;
	assign is_list_end    = lend_out_q;
	assign list_valid     = list_valid_q;
	assign accepted_count = accepted_q;

endmodule

// ----- hw/rtl/decimal_list_validator.sv -----
// ----------------------------------------------------------------------------
// Decimal list validator
// Parses delimited decimal tokens one byte per beat, range-checks each value,
// rejects duplicates against a table of accepted values and reports one
// result per closed token or list end.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  input     in_valid / in_ready   character, char_present, token_end, list_end
//  output    out_valid / out_ready value, token_number, token_status,
//                                  is_list_end, list_valid, accepted_count
//
// A beat that carries no token or list mark is absorbed without leaving the idle state.
// A beat that closes a token steps through the check, scan, last-read and
// finish states before the next input beat is taken; the duplicate scan
// reads the value table one entry per cycle through its single read port,
// covering every value stored so far in the list. A malformed token, an
// empty table or a bare list close skips the scan.
// Reset (arst_n low) clears all token and list state at once; the value table
// needs no clearing because only entries below the stored count are read.
// The result register holds a finished beat while the next bytes are taken; a
// further result waits in the controller until that register is free.
//
module decimal_list_validator
	import dlv_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              character,
	input  logic                    char_present,
	input  logic                    token_end,
	input  logic                    list_end,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] value,
	output logic [NUM_W-1:0]        token_number,
	output logic [STAT_W-1:0]       token_status,
	output logic                    is_list_end,
	output logic                    list_valid,
	output logic [NUM_W-1:0]        accepted_count
);

	// Commands from the controller and status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	// The controller sees only the handshake and whether the beat carries a
	// mark; everything about the token itself lives in the datapath.
	dlv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_marks(token_end || list_end),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dlv_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.character     (character),
		.char_present  (char_present),
		.token_end     (token_end),
		.list_end      (list_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.value         (value),
		.token_number  (token_number),
		.token_status  (token_status),
		.is_list_end   (is_list_end),
		.list_valid    (list_valid),
		.accepted_count(accepted_count)
	);

	// A valid list verdict is only given on a list-end beat.
	a_list_valid_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_valid) |-> is_list_end)
		else $error("list_valid raised on a beat that does not close the list");

	// A valid list cannot end on a rejected token.
	a_list_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && list_valid) |-> (token_status == ST_OK))
		else $error("list_valid raised with a failing token status");

	// A rejected token always reports a zero value.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (token_status != ST_OK)) |-> (value == '0))
		else $error("nonzero value on a rejected token");

	// Input is never taken while the duplicate scan is running.
	a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> !in_ready)
		else $error("input ready during table scan");

endmodule
